// File: hw/rtl/i2cseq_pkg.sv
// shared types, codes and constants for the i2c register transaction sequencer
package i2cseq_pkg;

	// input item kinds
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_EVENT = 2'd2;
	localparam logic [1:0] CMD_TICK  = 2'd3;

	// result actions
	localparam logic [2:0] ACT_START   = 3'd0;
	localparam logic [2:0] ACT_SEND    = 3'd1;
	localparam logic [2:0] ACT_RACK    = 3'd2;
	localparam logic [2:0] ACT_RNACK   = 3'd3;
	localparam logic [2:0] ACT_STOP    = 3'd4;
	localparam logic [2:0] ACT_DELIVER = 3'd5;
	localparam logic [2:0] ACT_DONE    = 3'd6;

	// error codes
	localparam logic [2:0] ERR_OK      = 3'd0;
	localparam logic [2:0] ERR_TIMEOUT = 3'd1;
	localparam logic [2:0] ERR_START   = 3'd2;
	localparam logic [2:0] ERR_ADDR_W  = 3'd3;
	localparam logic [2:0] ERR_ADDR_R  = 3'd4;
	localparam logic [2:0] ERR_DATA    = 3'd5;

	// masked bus status codes
	localparam logic [7:0] ST_MASK    = 8'hF8;
	localparam logic [7:0] ST_START   = 8'h08;
	localparam logic [7:0] ST_RSTART  = 8'h10;
	localparam logic [7:0] ST_SLAW    = 8'h18;
	localparam logic [7:0] ST_TX_ACK  = 8'h28;
	localparam logic [7:0] ST_SLAR    = 8'h40;
	localparam logic [7:0] ST_RX_ACK  = 8'h50;
	localparam logic [7:0] ST_RX_NACK = 8'h58;
	localparam logic [7:0] BYTE_FAIL  = 8'hFF;

	localparam logic [15:0] TIMEOUT_RESET = 16'd20000;
	localparam logic [15:0] WAIT_MAX      = 16'hFFFF;
	localparam int          MAX_READ_LEN_DEF = 64;

	// results per item and result queue depth
	localparam int MAX_RES   = 3;
	localparam int RES_DEPTH = 8;
	localparam int RES_PTR_W = $clog2(RES_DEPTH);
	localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

	// port widths
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 16;

	typedef struct packed {
		logic [6:0] dev_addr;
		logic [7:0] reg_addr;
		logic [7:0] wr_data;
		logic [6:0] count;
		logic [7:0] bus_status;
		logic [7:0] bus_data;
		logic [1:0] cmd;
	} item_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] out_byte;
		logic [2:0] error_code;
		logic       last;
	} res_t;

	// results of one item handed from the core to the result queue
	typedef struct packed {
		logic [1:0]           num;
		res_t [MAX_RES-1:0]   res;
	} push_t;

	function automatic res_t mk_res(logic [2:0] act, logic [7:0] b, logic [2:0] err);
		res_t r;
		r.action     = act;
		r.out_byte   = b;
		r.error_code = err;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

// File: hw/rtl/i2cseq_core.sv
// input register, transaction state and per-item result logic
module i2cseq_core
	import i2cseq_pkg::*;
#(
	parameter int MAX_READ_LEN = MAX_READ_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	input  logic        room,
	output push_t       push
);

	typedef enum logic [2:0] {
		PH_IDLE, PH_START, PH_SLAW, PH_REG, PH_WDATA, PH_RSTART, PH_SLAR, PH_RDATA
	} phase_t;

	phase_t      phase_q, phase_nx;
	logic [6:0]  addr_q, addr_nx;
	logic [7:0]  reg_q, reg_nx;
	logic [7:0]  wbyte_q, wbyte_nx;
	logic [6:0]  left_q, left_nx;
	logic        rd_q, rd_nx;
	logic [15:0] wait_q, wait_nx;
	logic [2:0]  ferr_q, ferr_nx;
	logic [15:0] limit_q;

	logic        valid_s1;
	item_t       item_s1;
	logic        fire;

	res_t [MAX_RES-1:0] res;
	logic [1:0]  num;

	// input stage
	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	// timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// next state and results of the item in the input stage
	always_comb begin
		logic        busy;
		logic        do_adv;
		logic        ok;
		logic [2:0]  err;
		logic [7:0]  rx;
		logic [7:0]  expect_st;
		logic [2:0]  ph_err;
		logic [6:0]  cnt;
		logic [6:0]  left_dec;
		logic [15:0] wait_inc;

		phase_nx = phase_q;
		addr_nx  = addr_q;
		reg_nx   = reg_q;
		wbyte_nx = wbyte_q;
		left_nx  = left_q;
		rd_nx    = rd_q;
		wait_nx  = wait_q;
		ferr_nx  = ferr_q;
		res      = '0;
		num      = 2'd0;
		busy     = (phase_q != PH_IDLE);
		do_adv   = 1'b0;
		ok       = 1'b0;
		err      = ERR_OK;
		rx       = 8'h00;
		cnt      = ({1'b0, item_s1.count} > 8'(MAX_READ_LEN)) ? 7'(MAX_READ_LEN)
			: item_s1.count;
		left_dec = (left_q != 7'd0) ? left_q - 7'd1 : 7'd0;
		wait_inc = (wait_q != WAIT_MAX) ? wait_q + 16'd1 : WAIT_MAX;

		// status expected for the pending bus command
		unique case (phase_q)
			PH_START:  expect_st = ST_START;
			PH_SLAW:   expect_st = ST_SLAW;
			PH_REG:    expect_st = ST_TX_ACK;
			PH_WDATA:  expect_st = ST_TX_ACK;
			PH_RSTART: expect_st = ST_RSTART;
			PH_SLAR:   expect_st = ST_SLAR;
			default:   expect_st = (left_q > 7'd1) ? ST_RX_ACK : ST_RX_NACK;
		endcase

		unique case (phase_q)
			PH_START, PH_RSTART: ph_err = ERR_START;
			PH_SLAW:             ph_err = ERR_ADDR_W;
			PH_SLAR:             ph_err = ERR_ADDR_R;
			default:             ph_err = ERR_DATA;
		endcase

		// item kind
		unique case (item_s1.cmd)
			CMD_WRITE, CMD_READ: begin
				if (!busy) begin
					addr_nx  = item_s1.dev_addr;
					reg_nx   = item_s1.reg_addr;
					wbyte_nx = item_s1.wr_data;
					rd_nx    = item_s1.cmd[0];
					ferr_nx  = ERR_OK;
					left_nx  = item_s1.cmd[0] ? cnt : 7'd0;
					wait_nx  = 16'd0;
					if (item_s1.cmd[0] && cnt == 7'd0) begin
						res[0]   = mk_res(ACT_DONE, 8'h00, ERR_OK);
						num      = 2'd1;
						phase_nx = PH_IDLE;
					end else begin
						res[0]   = mk_res(ACT_START, 8'h00, ERR_OK);
						num      = 2'd1;
						phase_nx = PH_START;
					end
				end
			end
			CMD_EVENT: begin
				if (busy) begin
					do_adv = 1'b1;
					ok     = ((item_s1.bus_status & ST_MASK) == expect_st);
					err    = ph_err;
					rx     = item_s1.bus_data;
				end
			end
			default: begin
				if (busy) begin
					wait_nx = wait_inc;
					if (wait_inc >= limit_q) begin
						do_adv = 1'b1;
						ok     = 1'b0;
						err    = ERR_TIMEOUT;
					end
				end
			end
		endcase

		// end of the pending bus command
		if (do_adv) begin
			wait_nx  = 16'd0;
			phase_nx = PH_IDLE;
			if (phase_q == PH_RDATA) begin
				if (!ok && ferr_q == ERR_OK) begin
					ferr_nx = err;
				end
				res[0]  = mk_res(ACT_DELIVER, ok ? rx : BYTE_FAIL, ok ? ERR_OK : err);
				left_nx = left_dec;
				if (left_dec != 7'd0) begin
					res[1]   = mk_res((left_dec > 7'd1) ? ACT_RACK : ACT_RNACK, 8'h00, ERR_OK);
					num      = 2'd2;
					phase_nx = PH_RDATA;
				end else begin
					res[1] = mk_res(ACT_STOP, 8'h00, ERR_OK);
					res[2] = mk_res(ACT_DONE, 8'h00, ferr_nx);
					num    = 2'd3;
				end
			end else if (!ok) begin
				// a failed first start leaves the bus without a stop
				if (phase_q == PH_START) begin
					res[0] = mk_res(ACT_DONE, 8'h00, err);
					num    = 2'd1;
				end else begin
					res[0] = mk_res(ACT_STOP, 8'h00, ERR_OK);
					res[1] = mk_res(ACT_DONE, 8'h00, err);
					num    = 2'd2;
				end
			end else begin
				num = 2'd1;
				unique case (phase_q)
					PH_START: begin
						res[0]   = mk_res(ACT_SEND, {addr_q, 1'b0}, ERR_OK);
						phase_nx = PH_SLAW;
					end
					PH_SLAW: begin
						res[0]   = mk_res(ACT_SEND, reg_q, ERR_OK);
						phase_nx = PH_REG;
					end
					PH_REG: begin
						if (rd_q) begin
							res[0]   = mk_res(ACT_START, 8'h00, ERR_OK);
							phase_nx = PH_RSTART;
						end else begin
							res[0]   = mk_res(ACT_SEND, wbyte_q, ERR_OK);
							phase_nx = PH_WDATA;
						end
					end
					PH_WDATA: begin
						res[0] = mk_res(ACT_STOP, 8'h00, ERR_OK);
						res[1] = mk_res(ACT_DONE, 8'h00, ERR_OK);
						num    = 2'd2;
					end
					PH_RSTART: begin
						res[0]   = mk_res(ACT_SEND, {addr_q, 1'b1}, ERR_OK);
						phase_nx = PH_SLAR;
					end
					default: begin
						res[0]   = mk_res((left_q > 7'd1) ? ACT_RACK : ACT_RNACK, 8'h00,
							ERR_OK);
						phase_nx = PH_RDATA;
					end
				endcase
			end
		end

		// mark the final result of this item
		for (int i = 0; i < MAX_RES; i++) begin
			res[i].last = (num == 2'(i + 1));
		end
	end

	// transaction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			addr_q  <= '0;
			reg_q   <= '0;
			wbyte_q <= '0;
			left_q  <= '0;
			rd_q    <= 1'b0;
			wait_q  <= '0;
			ferr_q  <= ERR_OK;
		end else if (fire) begin
			phase_q <= phase_nx;
			addr_q  <= addr_nx;
			reg_q   <= reg_nx;
			wbyte_q <= wbyte_nx;
			left_q  <= left_nx;
			rd_q    <= rd_nx;
			wait_q  <= wait_nx;
			ferr_q  <= ferr_nx;
		end
	end

	// results toward the queue
	assign push.num = fire ? num : 2'd0;
	assign push.res = res;

endmodule

// File: hw/rtl/i2cseq_fifo.sv
// result queue: takes up to three results per cycle, gives one per cycle while the receiver is ready
module i2cseq_fifo
	import i2cseq_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_res
);

	res_t                 mem [RES_DEPTH];
	logic [RES_PTR_W-1:0] wr_ptr_q;
	logic [RES_PTR_W-1:0] rd_ptr_q;
	logic [RES_CNT_W-1:0] cnt_q;
	logic                 pop;

	assign room      = (cnt_q <= RES_CNT_W'(RES_DEPTH - MAX_RES));
	assign out_valid = (cnt_q != '0);
	assign out_res   = mem[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	// result storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (2'(i) < push.num) begin
				mem[wr_ptr_q + RES_PTR_W'(i)] <= push.res[i];
			end
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RES_PTR_W'(push.num);
			rd_ptr_q <= rd_ptr_q + RES_PTR_W'(pop);
			cnt_q    <= cnt_q + RES_CNT_W'(push.num) - RES_CNT_W'(pop);
		end
	end

endmodule

// File: hw/rtl/i2c_register_transaction_sequencer.sv
// top level of the i2c register transaction sequencer
// One item (request, bus completion or tick) is taken per clock while the result queue
// has room for three results; its results are worked out from the input register and go
// into an eight-entry result queue. Results leave one per clock while the receiver is
// ready, so items that cause three results are held to the output rate; items that cause
// none (most ticks) run at one per clock. tlast marks the final result of an item. The user
// writes timeout_limit through cfg_wr_en / cfg_wr_data only while idle; not enforced here.
module i2c_register_transaction_sequencer
	import i2cseq_pkg::*;
#(
	parameter int MAX_READ_LEN = MAX_READ_LEN_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [15:0]           cfg_wr_data,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// dev_addr[6:0], reg_addr[14:7], wr_data[22:15], count[29:23],
	// bus_status[37:30], bus_data[45:38], zero[47:46]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	// cmd[1:0]
	input  logic [1:0]            s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// out_byte[7:0], error_code[10:8], zero[15:11]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// action[2:0]
	output logic [2:0]            m_axis_tuser,
	output logic                  m_axis_tlast
);

	item_t in_item;
	push_t push;
	logic  room;
	res_t  out_res;

	// unpack the input item
	assign in_item.dev_addr   = s_axis_tdata[6:0];
	assign in_item.reg_addr   = s_axis_tdata[14:7];
	assign in_item.wr_data    = s_axis_tdata[22:15];
	assign in_item.count      = s_axis_tdata[29:23];
	assign in_item.bus_status = s_axis_tdata[37:30];
	assign in_item.bus_data   = s_axis_tdata[45:38];
	assign in_item.cmd        = s_axis_tuser;

	i2cseq_core #(
		.MAX_READ_LEN(MAX_READ_LEN)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_item    (in_item),
		.room       (room),
		.push       (push)
	);

	i2cseq_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_res  (out_res)
	);

	// pack the result item
	assign m_axis_tdata = {5'b0, out_res.error_code, out_res.out_byte};
	assign m_axis_tuser = out_res.action;
	assign m_axis_tlast = out_res.last;

endmodule

// File: hw/rtl/i2cseq_checker.sv
// port-level checks on the result stream of the sequencer
module i2cseq_checker
	import i2cseq_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [2:0]            m_axis_tuser,
	input logic                  m_axis_tlast
);

	// a finished result always closes its item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ACT_DONE |-> m_axis_tlast)
	else $error("finished result without tlast");

	// a stop never closes its item
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ACT_STOP |-> !m_axis_tlast)
	else $error("stop closes an item");

	// only deliver and finished carry an error code
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ACT_DELIVER && m_axis_tuser != ACT_DONE
		|-> m_axis_tdata[10:8] == ERR_OK)
	else $error("error code on a bus command");

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
	else $error("stalled result changed");

endmodule

bind i2c_register_transaction_sequencer i2cseq_checker u_chk (.*);

// File: bench/tb.sv
// self-checking bench for the i2c register transaction sequencer
`timescale 1ns / 100ps

module tb;
	import i2cseq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 10;

	// transaction phase as tracked by the bench
	typedef enum logic [3:0] {
		PH_IDLE, PH_START, PH_SLAW, PH_REG, PH_WDATA, PH_RSTART, PH_SLAR, PH_RDATA
	} bus_phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// dev_addr, reg_addr, wr_data, count, bus_status, bus_data, zero pad
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	// cmd
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// out_byte, error_code, zero pad
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	// action
	logic [2:0] m_axis_tuser;
	logic m_axis_tlast;

	// sequencer state mirrored by the bench
	logic [15:0] tmo_limit = TIMEOUT_RESET;
	bus_phase_t bus_phase = PH_IDLE;
	logic [6:0] tgt_addr = '0;
	logic [7:0] tgt_reg = '0;
	logic [7:0] tgt_wbyte = '0;
	logic [6:0] rd_left = '0;
	logic rd_mode = 1'b0;
	logic [15:0] tick_count = '0;
	logic [2:0] rd_error = ERR_OK;

	res_t step_actions[$];
	res_t expected_actions[$];
	int work_items = 0;
	int errors = 0;
	int idle_odds = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	i2c_register_transaction_sequencer #(
		.MAX_READ_LEN(MAX_READ_LEN_DEF)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------- prediction ----------------

	function automatic void note(logic [2:0] act, logic [7:0] b, logic [2:0] err);
		res_t r;
		r.action = act;
		r.out_byte = b;
		r.error_code = err;
		r.last = 1'b0;
		step_actions.push_back(r);
	endfunction

	function automatic void start_command(bus_phase_t next);
		bus_phase = next;
		tick_count = '0;
	endfunction

	function automatic void close_transaction(logic with_stop, logic [2:0] err);
		if (with_stop)
			note(ACT_STOP, 8'h00, ERR_OK);
		note(ACT_DONE, 8'h00, err);
		bus_phase = PH_IDLE;
		tick_count = '0;
	endfunction

	// masked status that the pending bus command must report
	function automatic logic [7:0] status_wanted();
		case (bus_phase)
			PH_START:         return ST_START;
			PH_SLAW:          return ST_SLAW;
			PH_REG, PH_WDATA: return ST_TX_ACK;
			PH_RSTART:        return ST_RSTART;
			PH_SLAR:          return ST_SLAR;
			default:          return (rd_left > 1) ? ST_RX_ACK : ST_RX_NACK;
		endcase
	endfunction

	function automatic logic [2:0] phase_fault();
		case (bus_phase)
			PH_START, PH_RSTART: return ERR_START;
			PH_SLAW:             return ERR_ADDR_W;
			PH_SLAR:             return ERR_ADDR_R;
			default:             return ERR_DATA;
		endcase
	endfunction

	// end of one bus command, good or failed
	function automatic void finish_bus_command(logic ok, logic [2:0] err, logic [7:0] rx);
		if (bus_phase == PH_RDATA) begin
			// a failed read still delivers a byte and reading goes on
			if (!ok && rd_error == ERR_OK)
				rd_error = err;
			note(ACT_DELIVER, ok ? rx : BYTE_FAIL, ok ? ERR_OK : err);
			if (rd_left != 0)
				rd_left = rd_left - 1'b1;
			if (rd_left != 0) begin
				note((rd_left > 1) ? ACT_RACK : ACT_RNACK, 8'h00, ERR_OK);
				start_command(PH_RDATA);
			end else begin
				close_transaction(1'b1, rd_error);
			end
		end else if (!ok) begin
			// no stop after a failed first start
			close_transaction(bus_phase != PH_START, err);
		end else begin
			case (bus_phase)
				PH_START: begin
					note(ACT_SEND, {tgt_addr, 1'b0}, ERR_OK);
					start_command(PH_SLAW);
				end
				PH_SLAW: begin
					note(ACT_SEND, tgt_reg, ERR_OK);
					start_command(PH_REG);
				end
				PH_REG: begin
					if (rd_mode) begin
						note(ACT_START, 8'h00, ERR_OK);
						start_command(PH_RSTART);
					end else begin
						note(ACT_SEND, tgt_wbyte, ERR_OK);
						start_command(PH_WDATA);
					end
				end
				PH_WDATA: close_transaction(1'b1, ERR_OK);
				PH_RSTART: begin
					note(ACT_SEND, {tgt_addr, 1'b1}, ERR_OK);
					start_command(PH_SLAR);
				end
				default: begin
					note((rd_left > 1) ? ACT_RACK : ACT_RNACK, 8'h00, ERR_OK);
					start_command(PH_RDATA);
				end
			endcase
		end
	endfunction

	// apply one accepted item and queue the actions it causes
	function automatic void advance_sequencer(item_t it);
		logic busy;
		logic ok;
		logic [2:0] fault;
		logic [6:0] cnt;
		res_t r;
		busy = bus_phase != PH_IDLE;
		step_actions.delete();
		if (it.cmd == CMD_WRITE || it.cmd == CMD_READ) begin
			// requests while busy are dropped
			if (!busy) begin
				work_items++;
				tgt_addr = it.dev_addr;
				tgt_reg = it.reg_addr;
				tgt_wbyte = it.wr_data;
				rd_mode = it.cmd == CMD_READ;
				rd_error = ERR_OK;
				cnt = (it.count > MAX_READ_LEN_DEF) ? 7'(MAX_READ_LEN_DEF) : it.count;
				rd_left = rd_mode ? cnt : 7'd0;
				if (rd_mode && cnt == 0) begin
					close_transaction(1'b0, ERR_OK);
				end else begin
					note(ACT_START, 8'h00, ERR_OK);
					start_command(PH_START);
				end
			end
		end else if (busy) begin
			work_items++;
			if (it.cmd == CMD_EVENT) begin
				ok = (it.bus_status & ST_MASK) == status_wanted();
				fault = phase_fault();
				finish_bus_command(ok, fault, it.bus_data);
			end else begin
				if (tick_count != WAIT_MAX)
					tick_count = tick_count + 1'b1;
				if (tick_count >= tmo_limit)
					finish_bus_command(1'b0, ERR_TIMEOUT, 8'h00);
			end
		end
		foreach (step_actions[i]) begin
			r = step_actions[i];
			r.last = i == step_actions.size() - 1;
			expected_actions.push_back(r);
		end
	endfunction

	// ---------------- result checking ----------------

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_actions.size() == 0) begin
				$error("result with nothing expected: action %0d byte %0h",
					m_axis_tuser, m_axis_tdata[7:0]);
				errors++;
			end else begin
				want = expected_actions.pop_front();
				check_field("action", 8'(want.action), 8'(m_axis_tuser));
				check_field("out_byte", want.out_byte, m_axis_tdata[7:0]);
				check_field("error_code", 8'(want.error_code), 8'(m_axis_tdata[10:8]));
				check_field("last", 8'(want.last), 8'(m_axis_tlast));
			end
		end
	end

	// receiver stalls in random bursts while idle_odds is nonzero
	always @(posedge clk) begin
		if (idle_odds == 0) begin
			stall_left <= 0;
			m_axis_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(1, idle_odds) == 1) begin
			stall_left <= $urandom_range(0, 16);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("i2c_register_transaction_sequencer verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------- stimulus helpers ----------------

	function automatic item_t make_item(logic [1:0] kind);
		logic [63:0] bits;
		item_t it;
		bits = {$urandom, $urandom};
		it = bits[47:0];
		it.cmd = kind;
		return it;
	endfunction

	task automatic send_item(item_t it);
		if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, it.bus_data, it.bus_status, it.count, it.wr_data,
			it.reg_addr, it.dev_addr};
		s_axis_tuser <= it.cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		advance_sequencer(it);
	endtask

	task automatic request(logic [1:0] kind, logic [6:0] addr, logic [7:0] rg,
			logic [7:0] dat, logic [6:0] cnt);
		item_t it;
		it = make_item(kind);
		it.dev_addr = addr;
		it.reg_addr = rg;
		it.wr_data = dat;
		it.count = cnt;
		send_item(it);
	endtask

	task automatic bus_event(logic [7:0] status);
		item_t it;
		it = make_item(CMD_EVENT);
		it.bus_status = status;
		send_item(it);
	endtask

	// completion with the status the sequencer is waiting for
	task automatic bus_ok();
		bus_event(status_wanted() | 8'($urandom_range(0, 7)));
	endtask

	task automatic tick();
		send_item(make_item(CMD_TICK));
	endtask

	// hold the sender until every expected result is back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_actions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeout(logic [15:0] limit);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= limit;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tmo_limit = limit;
	endtask

	// ---------------- tests ----------------

	task automatic test_write_path();
		set_timeout(16'hFFFF);
		request(CMD_WRITE, 7'h7F, 8'hFF, 8'h00, 7'($urandom));
		repeat (4) bus_ok();
	endtask

	task automatic test_read_path();
		// two bytes, the first one fails and the error carries to the end
		request(CMD_READ, 7'h00, 8'h00, 8'hFF, 7'd2);
		repeat (5) bus_ok();
		bus_event(ST_RX_NACK);
		bus_ok();
		// zero count finishes without bus activity
		request(CMD_READ, 7'h55, 8'hA5, 8'($urandom), 7'd0);
	endtask

	task automatic test_special_cases();
		// completion and tick while idle are dropped
		tick();
		bus_event(ST_START);
		// request while busy is dropped, then start failure ends without stop
		request(CMD_WRITE, 7'h2A, 8'h3C, 8'hC3, 7'($urandom));
		request(CMD_READ, 7'h11, 8'h22, 8'h33, 7'd4);
		bus_event(8'h00);
		// repeated start failure still sends stop
		request(CMD_READ, 7'h6B, 8'h5A, 8'($urandom), 7'd3);
		repeat (3) bus_ok();
		bus_event(ST_START);
		// shortest timeout
		set_timeout(16'd1);
		request(CMD_WRITE, 7'h01, 8'h80, 8'h7E, 7'($urandom));
		tick();
	endtask

	// read far above the length cap, with scattered failures and ticks
	task automatic test_long_read();
		int r;
		set_timeout(16'hFFFF);
		request(CMD_READ, 7'($urandom), 8'($urandom), 8'($urandom), 7'h7F);
		while (bus_phase != PH_IDLE) begin
			r = $urandom_range(0, 99);
			// failures only on data bytes so the read runs to the cap
			if (r < 10 && bus_phase == PH_RDATA)
				bus_event(8'($urandom));
			else if (r < 22)
				tick();
			else
				bus_ok();
		end
	endtask

	// random transactions with random content, noise and broken sequences
	task automatic test_random(int n, int odds, logic [15:0] limit);
		int first;
		int r;
		logic [6:0] cnt;
		idle_odds = odds;
		set_timeout(limit);
		first = work_items;
		while (work_items - first < n) begin
			if ($urandom_range(0, 5) == 0) begin
				if ($urandom_range(0, 1) == 0)
					tick();
				else
					bus_event(8'($urandom));
			end
			r = $urandom_range(0, 19);
			if (r == 0)
				cnt = 7'd0;
			else if (r == 1)
				cnt = 7'($urandom_range(65, 127));
			else if (r < 5)
				cnt = 7'($urandom_range(5, 12));
			else
				cnt = 7'($urandom_range(1, 4));
			request($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, 7'($urandom),
				8'($urandom), 8'($urandom), cnt);
			while (bus_phase != PH_IDLE) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					bus_event(8'($urandom));
				else if (r < 20)
					tick();
				else if (r < 23)
					request($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, 7'($urandom),
						8'($urandom), 8'($urandom), 7'($urandom));
				else
					bus_ok();
			end
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_write_path();
		test_read_path();
		test_special_cases();
		idle_odds = 4;
		test_long_read();
		test_random(12, 4, 16'd1);
		test_random(10, 0, 16'hFFFF);
		test_random(12, 5, 16'($urandom_range(2, 6)));
		test_random(8, 0, 16'd3);
		idle_odds = 0;
		drain();
		if (errors == 0)
			$display("i2c_register_transaction_sequencer verification clean");
		else
			$display("i2c_register_transaction_sequencer verification failed");
		$finish;
	end

endmodule
